[rtl/srp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_pkg: shared types and constants for the trapezoid ramp planner
// Ramp period table, item kinds and the status bundle of one step.
// ----------------------------------------------------------------------------
package srp_pkg;

  localparam int TABLE_DEPTH  = 40;
  localparam int RAMP_ENTRIES = 40;
  localparam int POS_W        = 32;
  localparam int PERIOD_W     = 10;

  localparam logic KIND_PLAN = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef struct packed {
    logic stepped;
    logic direction;
    logic busy;
  } srp_status_t;

  // Step period for each ramp index, slowest first
  function automatic logic [PERIOD_W-1:0] ramp_period(input logic [5:0] i);
    logic [PERIOD_W-1:0] p;
    case (i)
      6'd0:  p = 10'd909;
      6'd1:  p = 10'd885;
      6'd2:  p = 10'd855;
      6'd3:  p = 10'd820;
      6'd4:  p = 10'd781;
      6'd5:  p = 10'd735;
      6'd6:  p = 10'd685;
      6'd7:  p = 10'd633;
      6'd8:  p = 10'd575;
      6'd9:  p = 10'd515;
      6'd10: p = 10'd457;
      6'd11: p = 10'd402;
      6'd12: p = 10'd348;
      6'd13: p = 10'd301;
      6'd14: p = 10'd259;
      6'd15: p = 10'd223;
      6'd16: p = 10'd192;
      6'd17: p = 10'd166;
      6'd18: p = 10'd145;
      6'd19: p = 10'd127;
      6'd20: p = 10'd113;
      6'd21: p = 10'd102;
      6'd22: p = 10'd93;
      6'd23: p = 10'd86;
      6'd24: p = 10'd80;
      6'd25: p = 10'd76;
      6'd26: p = 10'd72;
      6'd27: p = 10'd70;
      6'd28: p = 10'd68;
      6'd29: p = 10'd66;
      6'd30: p = 10'd65;
      6'd31: p = 10'd64;
      6'd32: p = 10'd63;
      6'd33: p = 10'd62;
      6'd34: p = 10'd62;
      6'd35: p = 10'd61;
      6'd36: p = 10'd61;
      6'd37: p = 10'd61;
      6'd38: p = 10'd61;
      default: p = 10'd60;
    endcase
    return p;
  endfunction

endpackage

[rtl/srp_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srp_engine: motion state and four-stage ramp sequencer
// Plans brake, accelerate, cruise and decelerate stages on a plan item and
// advances the first active stage by one step on a tick item.
// ----------------------------------------------------------------------------
module srp_engine #(
  parameter int TABLE_DEPTH = srp_pkg::TABLE_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 plan_en,
  input  logic                                 tick_en,
  input  logic        [srp_pkg::POS_W-1:0]     target,
  output srp_pkg::srp_status_t                 status,
  output logic signed [IDX_W-1:0]              speed_index,
  output logic        [srp_pkg::PERIOD_W-1:0]  step_period,
  output logic        [srp_pkg::POS_W-1:0]     position
);

  localparam int NSTAGE    = 4;
  localparam int ST_BRAKE  = 0;
  localparam int ST_UP     = 1;
  localparam int ST_CRUISE = 2;
  localparam int ST_DOWN   = 3;
  localparam int WIDE_W    = srp_pkg::POS_W + 2;

  localparam logic signed [IDX_W-1:0] IMAX      = IDX_W'(TABLE_DEPTH - 1);
  localparam logic signed [IDX_W-1:0] IDX_ZERO  = '0;
  localparam logic signed [IDX_W:0]   E_ONE     = (IDX_W+1)'(1);
  localparam logic signed [IDX_W:0]   E_M_ONE   = -(IDX_W+1)'(1);
  localparam logic signed [IDX_W:0]   E_IMAX    = (IDX_W+1)'(TABLE_DEPTH - 1);
  localparam logic signed [WIDE_W-1:0] W_IMAX   = WIDE_W'(TABLE_DEPTH - 1);
  localparam logic signed [WIDE_W-1:0] W_CRUISE = WIDE_W'(2 * (TABLE_DEPTH - 1));

  // Clamp an index into -1 .. top of table
  function automatic logic signed [IDX_W-1:0] hold(input logic signed [IDX_W:0] v);
    logic signed [IDX_W-1:0] r;
    if (v < E_M_ONE) begin
      r = -IDX_W'(1);
    end else if (v > E_IMAX) begin
      r = IMAX;
    end else begin
      r = v[IDX_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [IDX_W:0] ext(input logic signed [IDX_W-1:0] v);
    return {v[IDX_W-1], v};
  endfunction

  logic [srp_pkg::POS_W-1:0]    pos;
  logic                         cur_dir;
  logic signed [IDX_W-1:0]      sidx;
  logic [NSTAGE-1:0]            active;
  logic [NSTAGE-1:0]            st_dir;
  logic signed [IDX_W-1:0]      st_idx  [NSTAGE];
  logic signed [IDX_W-1:0]      st_goal [NSTAGE];
  logic [srp_pkg::POS_W-1:0]    cruise_left;

  logic [srp_pkg::POS_W-1:0]    pos_next;
  logic                         cur_dir_next;
  logic signed [IDX_W-1:0]      sidx_next;
  logic [NSTAGE-1:0]            active_next;
  logic [NSTAGE-1:0]            st_dir_next;
  logic signed [IDX_W-1:0]      st_idx_next  [NSTAGE];
  logic signed [IDX_W-1:0]      st_goal_next [NSTAGE];
  logic [srp_pkg::POS_W-1:0]    cruise_left_next;

  // ---------------------------------------------------------------- tick
  logic [1:0]                   found;
  logic                         any_active;
  logic                         f_dir;
  logic signed [IDX_W-1:0]      f_idx;
  logic signed [IDX_W-1:0]      f_goal;
  logic [NSTAGE-1:0]            t_active;
  logic signed [IDX_W-1:0]      t_idx;
  logic [srp_pkg::POS_W-1:0]    t_left;

  always_comb begin
    found = 2'(ST_DOWN);
    if (active[ST_BRAKE]) begin
      found = 2'(ST_BRAKE);
    end else if (active[ST_UP]) begin
      found = 2'(ST_UP);
    end else if (active[ST_CRUISE]) begin
      found = 2'(ST_CRUISE);
    end
  end

  assign any_active = |active;
  assign f_dir      = st_dir[found];
  assign f_idx      = st_idx[found];
  assign f_goal     = st_goal[found];

  always_comb begin
    t_active = active;
    t_idx    = f_idx;
    t_left   = cruise_left;
    if (any_active) begin
      case (found)
        2'(ST_UP): begin
          if (f_goal > f_idx) begin
            t_idx = hold(ext(f_idx) + E_ONE);
          end else begin
            t_active[found] = 1'b0;
          end
        end
        2'(ST_CRUISE): begin
          if (cruise_left > 32'd1) begin
            t_left = cruise_left - 32'd1;
          end else begin
            t_active[found] = 1'b0;
          end
        end
        default: begin
          if (f_goal < f_idx) begin
            t_idx = hold(ext(f_idx) - E_ONE);
          end else begin
            t_active[found] = 1'b0;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- plan
  logic [srp_pkg::POS_W-1:0]    diff;
  logic [srp_pkg::POS_W-1:0]    ndiff;
  logic                         fwd;
  logic signed [WIDE_W-1:0]     dist_w;
  logic signed [WIDE_W-1:0]     sidx_w;
  logic signed [WIDE_W-1:0]     total;
  logic signed [WIDE_W-1:0]     half;
  logic signed [WIDE_W-1:0]     left_w;
  logic                         brake_on;
  logic                         up_on;
  logic                         cruise_on;
  logic                         down_on;
  logic signed [IDX_W-1:0]      goal0, idx0, goal1, idx1, goal3, idx3;

  // Both differences in parallel; the sign of the first picks the magnitude
  assign diff   = target - pos;
  assign ndiff  = pos - target;
  assign fwd    = ~diff[srp_pkg::POS_W-1];
  assign dist_w = fwd ? WIDE_W'({1'b0, diff}) : WIDE_W'({1'b0, ndiff});
  assign sidx_w = WIDE_W'(sidx);
  assign total  = dist_w + sidx_w;
  // total never drops below -1, so halving toward zero is a shift
  assign half   = total[WIDE_W-1] ? '0 : (total >>> 1);
  assign left_w = total - W_CRUISE;

  always_comb begin
    brake_on = ((fwd == cur_dir) && (sidx_w > dist_w)) ||
               ((fwd != cur_dir) && (sidx != IDX_ZERO));
    goal0    = brake_on ? IDX_ZERO : sidx;
    idx0     = brake_on ? hold(ext(sidx) - E_ONE) : sidx;

    up_on    = half > WIDE_W'(goal0);
    goal1    = goal0;
    if (up_on) begin
      goal1 = (half >= W_IMAX) ? IMAX : half[IDX_W-1:0];
    end
    idx1     = up_on ? hold(ext(goal0) + E_ONE) : goal0;

    cruise_on = (goal1 == IMAX);

    down_on  = (total != '0);
    goal3    = down_on ? IDX_ZERO : goal1;
    idx3     = down_on ? hold(ext(goal1) - E_ONE) : goal1;
  end

  // ---------------------------------------------------------------- next
  always_comb begin
    pos_next         = pos;
    cur_dir_next     = cur_dir;
    sidx_next        = sidx;
    active_next      = active;
    st_dir_next      = st_dir;
    st_idx_next      = st_idx;
    st_goal_next     = st_goal;
    cruise_left_next = cruise_left;
    if (plan_en) begin
      active_next                = {down_on, cruise_on, up_on, brake_on};
      st_dir_next                = {fwd, fwd, fwd, cur_dir};
      st_idx_next[ST_BRAKE]      = idx0;
      st_goal_next[ST_BRAKE]     = goal0;
      st_idx_next[ST_UP]         = idx1;
      st_goal_next[ST_UP]        = goal1;
      st_idx_next[ST_CRUISE]     = goal1;
      st_goal_next[ST_CRUISE]    = goal1;
      st_idx_next[ST_DOWN]       = idx3;
      st_goal_next[ST_DOWN]      = goal3;
      cruise_left_next           = left_w[srp_pkg::POS_W-1:0];
    end else if (tick_en && any_active) begin
      active_next         = t_active;
      st_idx_next[found]  = t_idx;
      cruise_left_next    = t_left;
      pos_next            = f_dir ? pos + 32'd1 : pos - 32'd1;
      cur_dir_next        = f_dir;
      sidx_next           = f_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos         <= '0;
      cur_dir     <= 1'b1;
      sidx        <= '0;
      active      <= '0;
      st_dir      <= '0;
      cruise_left <= '0;
      for (int s = 0; s < NSTAGE; s++) begin
        st_idx[s]  <= '0;
        st_goal[s] <= '0;
      end
    end else begin
      pos         <= pos_next;
      cur_dir     <= cur_dir_next;
      sidx        <= sidx_next;
      active      <= active_next;
      st_dir      <= st_dir_next;
      st_idx      <= st_idx_next;
      st_goal     <= st_goal_next;
      cruise_left <= cruise_left_next;
    end
  end

  // ---------------------------------------------------------------- result
  logic signed [15:0] ix;

  assign ix = 16'(sidx_next);

  always_comb begin
    if (ix < 16'sd0) begin
      step_period = srp_pkg::ramp_period(6'd0);
    end else if (ix >= 16'(srp_pkg::RAMP_ENTRIES)) begin
      step_period = srp_pkg::ramp_period(6'(srp_pkg::RAMP_ENTRIES - 1));
    end else begin
      step_period = srp_pkg::ramp_period(ix[5:0]);
    end
  end

  assign status.stepped   = any_active;
  assign status.direction = cur_dir_next;
  assign status.busy      = |active_next;
  assign speed_index      = sidx_next;
  assign position         = pos_next;

endmodule

[rtl/stepper_trapezoid_ramp_planner.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_trapezoid_ramp_planner: trapezoidal speed ramp for a stepper drive
// Takes plan and tick beats, keeps the motion state, returns one step report
// per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Slave side: s_tuser selects the item (0 plans a move to the absolute
//   position in s_tdata, 1 is a step tick). A plan replaces any stages in
//   flight and replans from the present position, direction and speed.
//   Master side: one beat per tick carrying the step report; plans give none.
//   Path: an accepted tick waits in the input register and is processed
//   as its report is written. Throughput: one item per cycle unless a
//   tick waits on a stalled report; the whole plan or step is one register
//   to register pass through the sequencer.
//   Stall: while a report waits on m_tready, a pending tick holds in the
//   input register; plans still pass since they make no report.
//   Reset: position 0, direction forward, speed index 0, no stage active,
//   both registers empty.
// ----------------------------------------------------------------------------
module stepper_trapezoid_ramp_planner #(
  parameter int TABLE_DEPTH = srp_pkg::TABLE_DEPTH,
  parameter int IDX_W       = $clog2(TABLE_DEPTH) + 1,
  parameter int OUT_W       = ((45 + IDX_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [31:0]      s_tdata,   // target_position
  input  logic             s_tuser,   // kind
  output logic             m_tvalid,
  input  logic             m_tready,
  // stepped, direction, speed_index, step_period, position, busy_res, zero pad
  output logic [OUT_W-1:0] m_tdata
);

  localparam int PAD_W = OUT_W - (45 + IDX_W);

  logic                          in_valid;
  logic                          in_kind;
  logic [srp_pkg::POS_W-1:0]     in_target;
  logic                          out_free;
  logic                          advance;
  logic                          plan_en;
  logic                          tick_en;

  srp_pkg::srp_status_t          eng_status;
  logic signed [IDX_W-1:0]       eng_speed_index;
  logic [srp_pkg::PERIOD_W-1:0]  eng_period;
  logic [srp_pkg::POS_W-1:0]     eng_position;

  srp_pkg::srp_status_t          out_status;
  logic signed [IDX_W-1:0]       out_speed_index;
  logic [srp_pkg::PERIOD_W-1:0]  out_period;
  logic [srp_pkg::POS_W-1:0]     out_position;

  assign out_free = ~m_tvalid | m_tready;
  assign advance  = in_valid & ((in_kind == srp_pkg::KIND_PLAN) | out_free);
  assign plan_en  = advance & (in_kind == srp_pkg::KIND_PLAN);
  assign tick_en  = advance & (in_kind == srp_pkg::KIND_TICK);
  assign s_tready = ~in_valid | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind   <= s_tuser;
      in_target <= s_tdata;
    end
  end

  srp_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .plan_en     (plan_en),
    .tick_en     (tick_en),
    .target      (in_target),
    .status      (eng_status),
    .speed_index (eng_speed_index),
    .step_period (eng_period),
    .position    (eng_position)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (tick_en) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_en) begin
      out_status      <= eng_status;
      out_speed_index <= eng_speed_index;
      out_period      <= eng_period;
      out_position    <= eng_position;
    end
  end

  assign m_tdata = {PAD_W'(0), out_status.busy, out_position, out_period,
                    out_speed_index, out_status.direction, out_status.stepped};

  // A tick only moves into the result register when the slot is free
  a_tick_needs_slot: assert property (@(posedge clk) disable iff (rst)
    tick_en |-> out_free)
    else $error("tick processed while report stalled");

  // A tick that issues no step leaves no stage running
  a_idle_tick_not_busy: assert property (@(posedge clk) disable iff (rst)
    (tick_en && !eng_status.stepped) |-> !eng_status.busy)
    else $error("idle tick reports busy");

  // A held item keeps its payload until it is processed
  a_input_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> (in_valid && $stable(in_target) && $stable(in_kind)))
    else $error("pending item lost or changed");

  // A plan never disturbs a report that is still waiting
  a_plan_keeps_report: assert property (@(posedge clk) disable iff (rst)
    (plan_en && m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("plan disturbed a stalled report");

endmodule
